### hw/rtl/lirc_pkg.sv
`default_nettype none

package lirc_pkg;

    // Fixed field and register widths.
    localparam int RATE_W         = 18;
    localparam int CHIP_W         = 19;
    localparam int GAIN_W         = 9;
    localparam int CFG_DATA_W     = 19;
    localparam int CFG_IDX_W      = 2;
    localparam int ACC_W          = 20;
    localparam int MIX_W          = 32;
    localparam int SAMPLE_PORT_W  = 16;
    localparam int SAMPLE_MAX_W   = 24;
    localparam int PEAK_STORE_W   = 17;
    localparam int PEAK_OUT_W     = 16;
    localparam int TAKEN_W        = 2;

    // Gain is given in percent; the divider works on remainders of this width.
    localparam int GAIN_DIV       = 100;
    localparam int GAIN_DIV_W     = 7;

    localparam logic [RATE_W-1:0]       RATE_RESET = 18'd44100;
    localparam logic [CHIP_W-1:0]       CHIP_RESET = 19'd53267;
    localparam logic [GAIN_W-1:0]       GAIN_RESET = 9'd100;
    localparam logic [PEAK_STORE_W-1:0] PEAK_MAX   = 17'h1FFFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_RATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHIP_RATE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PERCENT = 2'd2;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MUL   = 8'b0000_0010,
        ST_DIV   = 8'b0000_0100,
        ST_LEVEL = 8'b0000_1000,
        ST_MAG   = 8'b0001_0000,
        ST_GMUL  = 8'b0010_0000,
        ST_GDIV  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/linear_interp_rate_converter.sv
`default_nettype none

// Stereo linear-interpolation rate converter and mixer. Each accepted input
// transfer is one output frame: both channels are interpolated between the
// previous and next source samples at the current phase, scaled by
// gain_percent / 100 (both divisions truncate toward zero), added with 32-bit
// wraparound to the incoming mix values, and a running peak of absolute levels
// is updated. The phase then advances by chip_rate and up to two of the offered
// source samples (a, then b) are consumed; samples_taken reports how many.
// One frame is worked at a time through bit-serial shift-add multipliers and
// restoring dividers, both channels side by side. After its input transfer a
// frame goes through the phase multiply (one phase bit a cycle), the division
// by output_rate (one quotient bit a cycle), the level and magnitude steps, the
// gain multiply, the division by 100 and the final sum, and its result is then
// offered. The next input transfer can be taken in the cycle after the result
// is loaded. A finished result waits in the output register without holding
// up the next frame; only the final load waits for that register to be free.
// Configuration writes are expected only while no frame is in flight.

module linear_interp_rate_converter #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_write,
    input  logic [lirc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lirc_pkg::CFG_DATA_W-1:0]        cfg_data,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [lirc_pkg::MIX_W-1:0]      mix_in_left,
    input  logic signed [lirc_pkg::MIX_W-1:0]      mix_in_right,
    input  logic signed [lirc_pkg::SAMPLE_PORT_W-1:0] sample_a_left,
    input  logic signed [lirc_pkg::SAMPLE_PORT_W-1:0] sample_a_right,
    input  logic signed [lirc_pkg::SAMPLE_PORT_W-1:0] sample_b_left,
    input  logic signed [lirc_pkg::SAMPLE_PORT_W-1:0] sample_b_right,
    input  logic                                   block_end,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [lirc_pkg::MIX_W-1:0]      mix_out_left,
    output logic signed [lirc_pkg::MIX_W-1:0]      mix_out_right,
    output logic [lirc_pkg::TAKEN_W-1:0]           samples_taken,
    output logic [lirc_pkg::PEAK_OUT_W-1:0]        peak_level,
    output logic                                   frame_last
);

    localparam int SB         = SAMPLE_BITS;
    localparam int RW         = lirc_pkg::RATE_W;
    localparam int GW         = lirc_pkg::GAIN_W;
    localparam int DW         = lirc_pkg::GAIN_DIV_W;
    localparam int MW         = lirc_pkg::MIX_W;
    localparam int AW         = lirc_pkg::ACC_W;
    localparam int PW         = lirc_pkg::PEAK_STORE_W;

    // Phase product |d| * ph and its quotient share one register per channel.
    localparam int PROD_W     = SB + RW;
    // Gain product |level| * gain; its quotient by 100 fits in SB + 2 bits.
    localparam int GPROD_W    = SB + GW;
    localparam int GQ_W       = GPROD_W - DW;

    localparam int MUL_STEPS  = RW;
    localparam int DIV_STEPS  = SB;
    localparam int GMUL_STEPS = GW;
    localparam int GDIV_STEPS = GQ_W;

    localparam int CNT_MAX    = (MUL_STEPS > GDIV_STEPS) ? MUL_STEPS : GDIV_STEPS;
    localparam int CW         = $clog2(CNT_MAX);
    localparam int ABS_W      = (SB > PW) ? SB : PW;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    lirc_pkg::state_t state_reg;
    lirc_pkg::state_t state_next;
    logic [CW-1:0]    cnt_reg;

    logic [RW-1:0]                  rate_reg;
    logic [lirc_pkg::CHIP_W-1:0]    chip_reg;
    logic [GW-1:0]                  gain_reg;

    logic signed [SB-1:0]           prev_reg  [2];
    logic signed [SB-1:0]           next_reg  [2];
    logic [RW-1:0]                  phase_reg;
    logic [PW-1:0]                  peak_reg;
    logic [AW-1:0]                  acc_reg;
    logic [lirc_pkg::TAKEN_W-1:0]   taken_reg;

    logic [MW-1:0]                  mix_reg   [2];
    logic [SB-1:0]                  samp_a_reg [2];
    logic [SB-1:0]                  samp_b_reg [2];
    logic                           last_reg;

    logic signed [SB-1:0]           base_reg  [2];
    logic                           neg_reg   [2];
    logic [SB-1:0]                  dmag_reg  [2];
    logic [PROD_W-1:0]              prod_reg  [2];
    logic signed [SB-1:0]           level_reg [2];
    logic                           lsign_reg [2];
    logic [SB-1:0]                  mag_reg   [2];
    logic [GPROD_W-1:0]             gprod_reg [2];

    logic                           out_valid_reg;
    logic [MW-1:0]                  mix_out_reg [2];
    logic [lirc_pkg::TAKEN_W-1:0]   taken_out_reg;
    logic [lirc_pkg::PEAK_OUT_W-1:0] peak_out_reg;
    logic                           last_out_reg;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic in_xfer;
    logic out_xfer;
    logic done_go;

    assign in_stall  = (state_reg != lirc_pkg::ST_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign done_go   = (state_reg == lirc_pkg::ST_DONE) && (!out_valid_reg || !out_stall);

    assign out_valid     = out_valid_reg;
    assign mix_out_left  = mix_out_reg[0];
    assign mix_out_right = mix_out_reg[1];
    assign samples_taken = taken_out_reg;
    assign peak_level    = peak_out_reg;
    assign frame_last    = last_out_reg;

    // ------------------------------------------------------------------
    // Channel datapath
    // ------------------------------------------------------------------
    logic [lirc_pkg::SAMPLE_PORT_W-1:0] port_a [2];
    logic [lirc_pkg::SAMPLE_PORT_W-1:0] port_b [2];
    logic [MW-1:0]                      port_mix [2];

    logic [SB-1:0]        conv_a     [2];
    logic [SB-1:0]        conv_b     [2];
    logic [SB:0]          d_fwd      [2];
    logic [SB:0]          d_bwd      [2];
    logic [SB-1:0]        dmag       [2];
    logic [SB:0]          mul_add    [2];
    logic [PROD_W-1:0]    mul_step   [2];
    logic [RW:0]          div_t      [2];
    logic [RW+1:0]        div_diff   [2];
    logic                 div_ge     [2];
    logic [PROD_W-1:0]    div_step   [2];
    logic [SB:0]          lvl_sum    [2];
    logic [SB-1:0]        level      [2];
    logic [SB-1:0]        mag        [2];
    logic [SB:0]          gmul_add   [2];
    logic [GPROD_W-1:0]   gmul_step  [2];
    logic [DW:0]          gdiv_t     [2];
    logic [DW+1:0]        gdiv_diff  [2];
    logic                 gdiv_ge    [2];
    logic [GPROD_W-1:0]   gdiv_step  [2];
    logic [MW-1:0]        mix_sum    [2];
    logic [ABS_W-1:0]     abs_ext    [2];
    logic [PW-1:0]        clamp      [2];
    logic [lirc_pkg::SAMPLE_MAX_W-1:0] ext_a [2];
    logic [lirc_pkg::SAMPLE_MAX_W-1:0] ext_b [2];

    always_comb
    begin
        port_a[0]   = sample_a_left;
        port_a[1]   = sample_a_right;
        port_b[0]   = sample_b_left;
        port_b[1]   = sample_b_right;
        port_mix[0] = mix_in_left;
        port_mix[1] = mix_in_right;

        for (int c = 0; c < 2; c++)
        begin
            // Offered samples are read from their low SAMPLE_BITS bits.
            ext_a[c]  = lirc_pkg::SAMPLE_MAX_W'(port_a[c]);
            ext_b[c]  = lirc_pkg::SAMPLE_MAX_W'(port_b[c]);
            conv_a[c] = ext_a[c][SB-1:0];
            conv_b[c] = ext_b[c][SB-1:0];

            // Magnitude and sign of next - prev, from two parallel subtractors.
            d_fwd[c] = {next_reg[c][SB-1], next_reg[c]} - {prev_reg[c][SB-1], prev_reg[c]};
            d_bwd[c] = {prev_reg[c][SB-1], prev_reg[c]} - {next_reg[c][SB-1], next_reg[c]};
            dmag[c]  = d_fwd[c][SB] ? d_bwd[c][SB-1:0] : d_fwd[c][SB-1:0];

            // Shift-add multiply: one phase bit a cycle, LSB first.
            mul_add[c]  = {1'b0, prod_reg[c][PROD_W-1:RW]}
                        + (prod_reg[c][0] ? {1'b0, dmag_reg[c]} : {(SB+1){1'b0}});
            mul_step[c] = {mul_add[c], prod_reg[c][RW-1:1]};

            // Restoring division by output_rate. The upper RW bits start
            // below the divisor, so only SB quotient bits are produced.
            div_t[c]    = {prod_reg[c][PROD_W-1:SB], prod_reg[c][SB-1]};
            div_diff[c] = {1'b0, div_t[c]} - {2'b00, rate_reg};
            div_ge[c]   = !div_diff[c][RW+1];
            div_step[c] = {(div_ge[c] ? div_diff[c][RW-1:0] : div_t[c][RW-1:0]),
                           prod_reg[c][SB-2:0], div_ge[c]};

            // level = prev +/- quotient, one adder with carry in.
            lvl_sum[c] = {base_reg[c][SB-1], base_reg[c]}
                       + ({1'b0, prod_reg[c][SB-1:0]} ^ {(SB+1){neg_reg[c]}})
                       + (SB+1)'(neg_reg[c]);
            level[c]   = (rate_reg == '0) ? base_reg[c] : lvl_sum[c][SB-1:0];

            mag[c] = (level_reg[c] ^ {SB{level_reg[c][SB-1]}}) + SB'(level_reg[c][SB-1]);

            // Gain multiply, one gain bit a cycle.
            gmul_add[c]  = {1'b0, gprod_reg[c][GPROD_W-1:GW]}
                         + (gprod_reg[c][0] ? {1'b0, mag_reg[c]} : {(SB+1){1'b0}});
            gmul_step[c] = {gmul_add[c], gprod_reg[c][GW-1:1]};

            // Restoring division by 100.
            gdiv_t[c]    = {gprod_reg[c][GPROD_W-1:GQ_W], gprod_reg[c][GQ_W-1]};
            gdiv_diff[c] = {1'b0, gdiv_t[c]} - (DW+2)'(lirc_pkg::GAIN_DIV);
            gdiv_ge[c]   = !gdiv_diff[c][DW+1];
            gdiv_step[c] = {(gdiv_ge[c] ? gdiv_diff[c][DW-1:0] : gdiv_t[c][DW-1:0]),
                            gprod_reg[c][GQ_W-2:0], gdiv_ge[c]};

            // Signed scaled value added to the mix with wraparound.
            mix_sum[c] = mix_reg[c]
                       + ({MW{lsign_reg[c]}} ^ MW'(gprod_reg[c][GQ_W-1:0]))
                       + MW'(lsign_reg[c]);

            abs_ext[c] = ABS_W'(mag_reg[c]);
            clamp[c]   = (abs_ext[c] > ABS_W'(lirc_pkg::PEAK_MAX)) ? lirc_pkg::PEAK_MAX
                                                                  : abs_ext[c][PW-1:0];
        end
    end

    // Phase used for interpolation never goes past the rate.
    logic [RW-1:0] ph_use;
    logic          acc_ge;
    logic [PW-1:0] peak_lr;
    logic [PW-1:0] peak_new;

    assign ph_use   = (phase_reg > rate_reg) ? rate_reg : phase_reg;
    assign acc_ge   = (acc_reg >= AW'(rate_reg));
    assign peak_lr  = (clamp[0] > clamp[1]) ? clamp[0] : clamp[1];
    assign peak_new = (peak_lr > peak_reg) ? peak_lr : peak_reg;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lirc_pkg::ST_IDLE:
                if (in_xfer)
                    state_next = lirc_pkg::ST_MUL;
            lirc_pkg::ST_MUL:
                if (cnt_reg == '0)
                    state_next = lirc_pkg::ST_DIV;
            lirc_pkg::ST_DIV:
                if (cnt_reg == '0)
                    state_next = lirc_pkg::ST_LEVEL;
            lirc_pkg::ST_LEVEL:
                state_next = lirc_pkg::ST_MAG;
            lirc_pkg::ST_MAG:
                state_next = lirc_pkg::ST_GMUL;
            lirc_pkg::ST_GMUL:
                if (cnt_reg == '0)
                    state_next = lirc_pkg::ST_GDIV;
            lirc_pkg::ST_GDIV:
                if (cnt_reg == '0)
                    state_next = lirc_pkg::ST_DONE;
            lirc_pkg::ST_DONE:
                if (done_go)
                    state_next = lirc_pkg::ST_IDLE;
            default:
                state_next = lirc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lirc_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            priority if (in_xfer)
                cnt_reg <= CW'(MUL_STEPS - 1);
            else if (state_reg == lirc_pkg::ST_MUL && cnt_reg == '0)
                cnt_reg <= CW'(DIV_STEPS - 1);
            else if (state_reg == lirc_pkg::ST_MAG)
                cnt_reg <= CW'(GMUL_STEPS - 1);
            else if (state_reg == lirc_pkg::ST_GMUL && cnt_reg == '0)
                cnt_reg <= CW'(GDIV_STEPS - 1);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Configuration and frame state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= lirc_pkg::RATE_RESET;
            chip_reg  <= lirc_pkg::CHIP_RESET;
            gain_reg  <= lirc_pkg::GAIN_RESET;
            prev_reg  <= '{default: '0};
            next_reg  <= '{default: '0};
            phase_reg <= '0;
            peak_reg  <= '0;
            acc_reg   <= '0;
            taken_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == lirc_pkg::CFG_OUTPUT_RATE)
                    rate_reg <= cfg_data[RW-1:0];
                if (cfg_index == lirc_pkg::CFG_CHIP_RATE)
                    chip_reg <= cfg_data[lirc_pkg::CHIP_W-1:0];
                if (cfg_index == lirc_pkg::CFG_GAIN_PERCENT)
                    gain_reg <= cfg_data[GW-1:0];
            end

            if (in_xfer)
            begin
                acc_reg   <= AW'(phase_reg) + AW'(chip_reg);
                taken_reg <= '0;
            end

            // The phase advance rides along the start of the multiply:
            // up to two sample takes, then the wrap limit.
            if (state_reg == lirc_pkg::ST_MUL)
            begin
                if ((cnt_reg == CW'(MUL_STEPS - 1) || cnt_reg == CW'(MUL_STEPS - 2))
                    && rate_reg != '0 && acc_ge)
                begin
                    acc_reg   <= acc_reg - AW'(rate_reg);
                    taken_reg <= taken_reg + 1'b1;
                    for (int c = 0; c < 2; c++)
                    begin
                        prev_reg[c] <= next_reg[c];
                        next_reg[c] <= (taken_reg == '0) ? samp_a_reg[c] : samp_b_reg[c];
                    end
                end
                if (cnt_reg == CW'(MUL_STEPS - 3))
                begin
                    if (rate_reg == '0)
                        phase_reg <= '0;
                    else if (acc_ge)
                        phase_reg <= rate_reg - 1'b1;
                    else
                        phase_reg <= acc_reg[RW-1:0];
                end
            end

            if (state_reg == lirc_pkg::ST_GMUL && cnt_reg == CW'(GMUL_STEPS - 1))
                peak_reg <= peak_new;
        end
    end

    // ------------------------------------------------------------------
    // Serial datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            last_reg <= block_end;

        for (int c = 0; c < 2; c++)
        begin
            if (in_xfer)
            begin
                mix_reg[c]    <= port_mix[c];
                samp_a_reg[c] <= conv_a[c];
                samp_b_reg[c] <= conv_b[c];
                base_reg[c]   <= prev_reg[c];
                neg_reg[c]    <= d_fwd[c][SB];
                dmag_reg[c]   <= dmag[c];
                prod_reg[c]   <= PROD_W'(ph_use);
            end
            else if (state_reg == lirc_pkg::ST_MUL)
                prod_reg[c] <= mul_step[c];
            else if (state_reg == lirc_pkg::ST_DIV)
                prod_reg[c] <= div_step[c];

            if (state_reg == lirc_pkg::ST_LEVEL)
                level_reg[c] <= level[c];

            if (state_reg == lirc_pkg::ST_MAG)
            begin
                mag_reg[c]   <= mag[c];
                lsign_reg[c] <= level_reg[c][SB-1];
                gprod_reg[c] <= GPROD_W'(gain_reg);
            end
            else if (state_reg == lirc_pkg::ST_GMUL)
                gprod_reg[c] <= gmul_step[c];
            else if (state_reg == lirc_pkg::ST_GDIV)
                gprod_reg[c] <= gdiv_step[c];
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (done_go)
            out_valid_reg <= 1'b1;
        else if (out_xfer)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done_go)
        begin
            mix_out_reg[0] <= mix_sum[0];
            mix_out_reg[1] <= mix_sum[1];
            taken_out_reg  <= taken_reg;
            peak_out_reg   <= peak_reg[lirc_pkg::PEAK_OUT_W-1:0];
            last_out_reg   <= last_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == lirc_pkg::ST_MUL)
        else $error("frame transfer did not start the phase multiply");

    a_phase_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lirc_pkg::ST_DONE && rate_reg != '0) |-> phase_reg < rate_reg)
        else $error("phase not below output rate at end of frame");

    a_taken_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> taken_out_reg != 2'd3)
        else $error("more than two source samples taken");

    a_peak_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> peak_reg >= $past(peak_reg))
        else $error("running peak decreased");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == lirc_pkg::ST_DONE))
        else $error("result offered outside the final sequencer step");

endmodule

`default_nettype wire

### dv/linear_interp_rate_converter_tb.sv
`timescale 1ns / 1ps

module linear_interp_rate_converter_tb;

    import lirc_pkg::*;

    // The package names only the three live registers; index 3 decodes to nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int MAX_REPORTS  = 10;
    // This tail covers one full frame time.
    localparam int LATENCY_TAIL = 80;

    // One input transfer and one result transfer, packed for the queue.
    typedef struct packed {
        logic [MIX_W-1:0]         mix_l;
        logic [MIX_W-1:0]         mix_r;
        logic [SAMPLE_PORT_W-1:0] a_l;
        logic [SAMPLE_PORT_W-1:0] a_r;
        logic [SAMPLE_PORT_W-1:0] b_l;
        logic [SAMPLE_PORT_W-1:0] b_r;
        logic                     last;
    } frame_in_t;

    typedef struct packed {
        logic [MIX_W-1:0]      mix_l;
        logic [MIX_W-1:0]      mix_r;
        logic [TAKEN_W-1:0]    taken;
        logic [PEAK_OUT_W-1:0] peak;
        logic                  last;
    } frame_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]            cfg_index = CFG_OUTPUT_RATE;
    logic [CFG_DATA_W-1:0]           cfg_data = '0;

    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic signed [MIX_W-1:0]         mix_in_left = '0;
    logic signed [MIX_W-1:0]         mix_in_right = '0;
    logic signed [SAMPLE_PORT_W-1:0] sample_a_left = '0;
    logic signed [SAMPLE_PORT_W-1:0] sample_a_right = '0;
    logic signed [SAMPLE_PORT_W-1:0] sample_b_left = '0;
    logic signed [SAMPLE_PORT_W-1:0] sample_b_right = '0;
    logic                            block_end = 1'b0;

    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic signed [MIX_W-1:0]         mix_out_left;
    logic signed [MIX_W-1:0]         mix_out_right;
    logic [TAKEN_W-1:0]              samples_taken;
    logic [PEAK_OUT_W-1:0]           peak_level;
    logic                            frame_last;

    // Percent of cycles in which the sender holds off and the receiver stalls.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int mismatch_count = 0;
    int cycle_count = 0;

    // Mixed frames that the converter still owes us, oldest first.
    frame_out_t mix_results_due[$];

    // Shadow of the converter: register copies and interpolation state, all at
    // their reset values, since reset is applied exactly once.
    logic [RATE_W-1:0]       rate_reg = RATE_RESET;
    logic [CHIP_W-1:0]       chip_reg = CHIP_RESET;
    logic [GAIN_W-1:0]       gain_reg = GAIN_RESET;
    longint                  prev_l = 0;
    longint                  prev_r = 0;
    longint                  next_l = 0;
    longint                  next_r = 0;
    int unsigned             phase_acc = 0;
    logic [PEAK_STORE_W-1:0] peak_hold = '0;

    linear_interp_rate_converter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mix_in_left    (mix_in_left),
        .mix_in_right   (mix_in_right),
        .sample_a_left  (sample_a_left),
        .sample_a_right (sample_a_right),
        .sample_b_left  (sample_b_left),
        .sample_b_right (sample_b_right),
        .block_end      (block_end),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .mix_out_left   (mix_out_left),
        .mix_out_right  (mix_out_right),
        .samples_taken  (samples_taken),
        .peak_level     (peak_level),
        .frame_last     (frame_last)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Level between two source samples at the given phase. The division is
    // signed 64-bit, which truncates toward zero as the hardware must.
    function automatic longint interp_level(longint p, longint n, int unsigned ph);
        if (rate_reg == '0)
            return p;
        return p + ((n - p) * longint'(ph)) / longint'(rate_reg);
    endfunction

    // Gain is in percent; the scaled value is added to the 32-bit accumulator
    // and simply wraps, so only its low 32 bits matter.
    function automatic logic [MIX_W-1:0] scale_level(longint lvl);
        longint scaled;
        scaled = (lvl * longint'(gain_reg)) / longint'(GAIN_DIV);
        return scaled[MIX_W-1:0];
    endfunction

    function automatic void note_peak(longint lvl);
        longint mag;
        mag = (lvl < 0) ? -lvl : lvl;
        if (mag > PEAK_MAX)
            mag = PEAK_MAX;
        if (mag > peak_hold)
            peak_hold = mag[PEAK_STORE_W-1:0];
    endfunction

    // Works out one output frame and advances the shadow state exactly as the
    // converter does when it accepts the frame.
    function automatic frame_out_t convert_frame(frame_in_t f);
        frame_out_t  r;
        int unsigned ph;
        int unsigned acc;
        int          used;
        longint      lvl_l;
        longint      lvl_r;

        // After output_rate is lowered the phase can sit above it; the
        // interpolation clamps it so the level never leaves [prev, next].
        ph = (phase_acc > rate_reg) ? rate_reg : phase_acc;
        lvl_l = interp_level(prev_l, next_l, ph);
        lvl_r = interp_level(prev_r, next_r, ph);
        r.mix_l = f.mix_l + scale_level(lvl_l);
        r.mix_r = f.mix_r + scale_level(lvl_r);
        note_peak(lvl_l);
        note_peak(lvl_r);

        used = 0;
        if (rate_reg == '0)
        begin
            phase_acc = 0;
        end
        else
        begin
            acc = phase_acc + chip_reg;
            while (used < 2 && acc >= rate_reg)
            begin
                acc -= rate_reg;
                prev_l = next_l;
                prev_r = next_r;
                if (used == 0)
                begin
                    next_l = longint'($signed(f.a_l));
                    next_r = longint'($signed(f.a_r));
                end
                else
                begin
                    next_l = longint'($signed(f.b_l));
                    next_r = longint'($signed(f.b_r));
                end
                used++;
            end
            // A source that runs too fast is held one step short of a take.
            if (acc >= rate_reg)
                acc = rate_reg - 1;
            phase_acc = acc & 32'h3FFFF;
        end

        r.taken = used[TAKEN_W-1:0];
        r.peak = peak_hold[PEAK_OUT_W-1:0];
        r.last = f.last;
        return r;
    endfunction

    function automatic logic [SAMPLE_PORT_W-1:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [MIX_W-1:0] pick_mix();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Writes all three registers back to back, optionally followed by a write
    // to the unused index, and keeps the shadow copies in step. Called only at
    // a rising edge while nothing is in flight.
    task automatic set_regs(input logic [CFG_DATA_W-1:0] rate_word,
                            input logic [CFG_DATA_W-1:0] chip_word,
                            input logic [CFG_DATA_W-1:0] gain_word,
                            input bit poke_unused);
        cfg_write <= 1'b1;
        cfg_index <= CFG_OUTPUT_RATE;
        cfg_data <= rate_word;
        @(posedge clk);
        rate_reg = rate_word[RATE_W-1:0];
        cfg_index <= CFG_CHIP_RATE;
        cfg_data <= chip_word;
        @(posedge clk);
        chip_reg = chip_word[CHIP_W-1:0];
        cfg_index <= CFG_GAIN_PERCENT;
        cfg_data <= gain_word;
        @(posedge clk);
        gain_reg = gain_word[GAIN_W-1:0];
        if (poke_unused)
        begin
            cfg_index <= CFG_UNUSED;
            cfg_data <= '1;
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    // Offers one frame and returns at the rising edge where the transfer took
    // place. in_valid is left high so a following frame can go out in the very
    // next cycle; each call assigns it at most once per time step. Stall is
    // sampled at the falling edge, where every input and register is settled.
    task automatic send_frame(input logic [MIX_W-1:0] ml, input logic [MIX_W-1:0] mr,
                              input logic [SAMPLE_PORT_W-1:0] al,
                              input logic [SAMPLE_PORT_W-1:0] ar,
                              input logic [SAMPLE_PORT_W-1:0] bl,
                              input logic [SAMPLE_PORT_W-1:0] br,
                              input logic last);
        frame_in_t f;
        bit        accepted;
        f = '{ml, mr, al, ar, bl, br, last};
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mix_in_left <= ml;
        mix_in_right <= mr;
        sample_a_left <= al;
        sample_a_right <= ar;
        sample_b_left <= bl;
        sample_b_right <= br;
        block_end <= last;
        do
        begin
            @(negedge clk);
            accepted = !in_stall;
            @(posedge clk);
        end
        while (!accepted);
        mix_results_due.push_back(convert_frame(f));
    endtask

    // Drops valid and waits for every owed frame. Each input yields exactly one
    // result, so an empty queue means the converter is idle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (mix_results_due.size() != 0)
            @(posedge clk);
    endtask

    // Reset register values with extreme samples and accumulators; the default
    // rates take one sample per frame and now and then two.
    task automatic test_reset_defaults();
        send_idle_pct = 27;
        recv_idle_pct = 51;
        send_frame(32'h0000_0000, 32'h0000_0000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1'b0);
        send_frame(32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b1);
        send_frame(32'hFFFF_FFFF, 32'h0000_0000, 16'h0000, 16'hFFFF, 16'h0001, 16'h0000, 1'b0);
        send_frame(32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1'b1);
        send_frame(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
        send_frame(32'h8000_0000, 32'h8000_0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
        wait_idle();
    endtask

    // Register extremes and the corner behaviors: a full-width output rate with the
    // largest gain, a big phase left over when the rate is then cut (phase
    // clamp) together with a source far too fast (two takes and the hold), a
    // zero output rate with zero gain and a write to the unused index, and a
    // chip rate of zero that never takes a sample.
    task automatic test_extreme_settings();
        set_regs(19'h3FFFF, 19'd250000, 19'd511, 1'b0);
        send_frame(32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1'b0);
        send_frame(32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b1);
        wait_idle();

        set_regs(19'd8000, 19'd384000, 19'd400, 1'b0);
        send_frame(32'h0000_0000, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1'b0);
        send_frame(32'h8000_0000, 32'h7FFF_FFFF, 16'h1234, 16'hEDCB, 16'h8000, 16'h7FFF, 1'b1);
        send_frame(32'h1234_5678, 32'h8765_4321, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 1'b0);
        wait_idle();

        set_regs(19'd0, 19'h7FFFF, 19'd0, 1'b1);
        send_frame(32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b1);
        send_frame(32'hFFFF_FFFF, 32'h0000_0001, 16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF, 1'b0);
        wait_idle();

        set_regs(19'd192000, 19'd0, 19'd100, 1'b0);
        send_frame(32'h0000_0000, 32'h0000_0000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1'b1);
        send_frame(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b0);
        wait_idle();
    endtask

    // Random traffic in bursts, each under a freshly drawn register setting.
    // Most settings are legal (chip rate under twice the output rate); some are
    // extremes, too-fast sources, zero rates or gains past 400, and some carry
    // junk in data bits above the register's width.
    task automatic test_random_traffic(input int frames, input int send_pct,
                                       input int recv_pct);
        int                    sent;
        int                    burst;
        int unsigned           rate;
        int unsigned           chip;
        int unsigned           gain;
        int unsigned           chip_top;
        logic [CFG_DATA_W-1:0] rate_word;
        logic [CFG_DATA_W-1:0] gain_word;

        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < frames)
        begin
            case ($urandom_range(15))
                0: rate = 0;
                1: rate = 32'h3FFFF;
                2: rate = 8000;
                default: rate = $urandom_range(192000, 8000);
            endcase
            chip_top = (rate >= 192000 || rate < 8000) ? 384000 : 2 * rate - 1;
            case ($urandom_range(15))
                0: chip = 0;
                1: chip = 32'h7FFFF;
                2, 3: chip = $urandom_range(384000, 8000);
                default: chip = $urandom_range(chip_top, 8000);
            endcase
            case ($urandom_range(7))
                0: gain = $urandom_range(511, 401);
                1: gain = 0;
                2: gain = 400;
                default: gain = $urandom_range(400);
            endcase
            rate_word = rate[CFG_DATA_W-1:0];
            gain_word = gain[CFG_DATA_W-1:0];
            if ($urandom_range(3) == 0)
            begin
                rate_word[CFG_DATA_W-1] = $urandom_range(1);
                gain_word[CFG_DATA_W-1:GAIN_W] = $urandom();
            end
            set_regs(rate_word, chip[CFG_DATA_W-1:0], gain_word, $urandom_range(7) == 0);

            burst = $urandom_range(60, 10);
            repeat (burst)
            begin
                send_frame(pick_mix(), pick_mix(), pick_sample(), pick_sample(),
                           pick_sample(), pick_sample(), $urandom_range(1));
            end
            sent += burst;
            wait_idle();
        end
    endtask

    // The receiver stalls at random in the share of cycles the current phase
    // asks for.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Result transfers are checked at the falling edge before the rising edge
    // that completes them; valid, stall and the payload are all stable there.
    always @(negedge clk)
    begin : check_results
        frame_out_t want;
        frame_out_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{mix_out_left, mix_out_right, samples_taken, peak_level, frame_last};
            if (mix_results_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result transfer: mix %h/%h taken %0d peak %0d last %b",
                             got.mix_l, got.mix_r, got.taken, got.peak, got.last);
            end
            else
            begin
                want = mix_results_due.pop_front();
                if (got.mix_l !== want.mix_l || got.mix_r !== want.mix_r ||
                    got.taken !== want.taken || got.peak !== want.peak ||
                    got.last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"mismatch: mix_out_left %h/%h mix_out_right %h/%h ",
                                  "samples_taken %0d/%0d peak_level %0d/%0d ",
                                  "frame_last %b/%b (expected/actual)"},
                                 want.mix_l, got.mix_l, want.mix_r, got.mix_r,
                                 want.taken, got.taken, want.peak, got.peak,
                                 want.last, got.last);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_extreme_settings();
        // The sender gaps and receiver stalls swap roles, then both stop.
        test_random_traffic(500, 27, 51);
        test_random_traffic(500, 51, 27);
        test_random_traffic(500, 0, 0);

        // Give a stray extra result a full frame time to show up.
        repeat (LATENCY_TAIL) @(posedge clk);
        if (mismatch_count == 0 && mix_results_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
